@@ hw/rtl/abcr_pkg.sv @@
// ----------------------------------------------------------------------------
// abcr_pkg
// Axis codes, velocity action codes and the control flags that travel with an
// item through the collision resolve pipeline.
// ----------------------------------------------------------------------------
package abcr_pkg;

    localparam logic [1:0] MODE_X    = 2'd0;
    localparam logic [1:0] MODE_Y    = 2'd1;
    localparam logic [1:0] MODE_Z    = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] VEL_KEEP  = 2'd0;
    localparam logic [1:0] VEL_ZERO  = 2'd1;
    localparam logic [1:0] VEL_BOX_Y = 2'd2;

    typedef struct packed {
        logic no_axis;
        logic is_y;
        logic cross_ovl;
        logic pos_hit;
        logic mv_neg;
        logic mv_pos;
    } abcr_ctl_t;

endpackage

@@ hw/rtl/abcr_in_if.sv @@
// ----------------------------------------------------------------------------
// abcr_in_if
// Item channel: one box and one object to resolve along a chosen axis.
// ----------------------------------------------------------------------------
interface abcr_in_if #(
    parameter int COORD_BITS = 20
);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic [3*COORD_BITS-1:0]        box_pos;
    logic signed [COORD_BITS-1:0]   box_old_axis;
    logic [3*COORD_BITS-1:0]        box_half;
    logic [3*COORD_BITS-1:0]        box_motion;
    logic [3*COORD_BITS-1:0]        obj_pos;
    logic signed [COORD_BITS-1:0]   obj_old_axis;
    logic [3*COORD_BITS-1:0]        obj_size;

    modport source (
        output valid, mode, box_pos, box_old_axis, box_half, box_motion,
               obj_pos, obj_old_axis, obj_size,
        input  ready
    );

    modport sink (
        input  valid, mode, box_pos, box_old_axis, box_half, box_motion,
               obj_pos, obj_old_axis, obj_size,
        output ready
    );
endinterface

@@ hw/rtl/abcr_out_if.sv @@
// ----------------------------------------------------------------------------
// abcr_out_if
// Result channel: corrected coordinate and the response flags.
// ----------------------------------------------------------------------------
interface abcr_out_if #(
    parameter int COORD_BITS = 20
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS-1:0]   obj_axis_out;
    logic                           pos_written;
    logic [1:0]                     vel_action;
    logic                           landed;

    modport source (
        output valid, obj_axis_out, pos_written, vel_action, landed,
        input  ready
    );

    modport sink (
        input  valid, obj_axis_out, pos_written, vel_action, landed,
        output ready
    );
endinterface

@@ hw/rtl/abcr_prep.sv @@
// ----------------------------------------------------------------------------
// abcr_prep
// Picks the tested axis, checks overlap on the two other axes and forms the
// face sums used by the later stages.
// ----------------------------------------------------------------------------
module abcr_prep #(
    parameter int COORD_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [3*COORD_BITS-1:0]         box_pos,
    input  logic signed [COORD_BITS-1:0]    box_old_axis,
    input  logic [3*COORD_BITS-1:0]         box_half,
    input  logic [3*COORD_BITS-1:0]         box_motion,
    input  logic [3*COORD_BITS-1:0]         obj_pos,
    input  logic signed [COORD_BITS-1:0]    obj_old_axis,
    input  logic [3*COORD_BITS-1:0]         obj_size,
    output logic                            out_valid,
    input  logic                            out_ready,
    output abcr_pkg::abcr_ctl_t             ctl,
    output logic signed [COORD_BITS+2:0]    bp,
    output logic signed [COORD_BITS+2:0]    bpo,
    output logic signed [COORD_BITS+2:0]    ol,
    output logic signed [COORD_BITS+2:0]    olo,
    output logic signed [COORD_BITS+2:0]    bn,
    output logic signed [COORD_BITS+2:0]    bno,
    output logic signed [COORD_BITS+2:0]    oho,
    output logic signed [COORD_BITS+2:0]    c_old,
    output logic signed [COORD_BITS+2:0]    lm,
    output logic signed [COORD_BITS+2:0]    sm,
    output logic [COORD_BITS-1:0]           s,
    output logic signed [COORD_BITS-1:0]    p
);
    import abcr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic signed [EW-1:0]   b_e  [3];
    logic signed [EW-1:0]   h_e  [3];
    logic signed [EW-1:0]   mv_e [3];
    logic signed [EW-1:0]   p_e  [3];
    logic signed [EW-1:0]   s_e  [3];
    logic [2:0]             ov;
    logic [1:0]             ax;
    logic                   cross_ovl;
    logic signed [EW-1:0]   b, h, mv, pa, sa, bold, pold, loff;
    logic                   load;

    logic                   valid_reg, valid_next;
    abcr_ctl_t              ctl_reg, ctl_next;
    logic signed [EW-1:0]   bp_reg, bp_next, bpo_reg, bpo_next;
    logic signed [EW-1:0]   ol_reg, ol_next, olo_reg, olo_next;
    logic signed [EW-1:0]   bn_reg, bn_next, bno_reg, bno_next;
    logic signed [EW-1:0]   oho_reg, oho_next, c_old_reg, c_old_next;
    logic signed [EW-1:0]   lm_reg, lm_next, sm_reg, sm_next;
    logic [W-1:0]           s_reg, s_next;
    logic signed [W-1:0]    p_reg, p_next;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign b_e[k]  = EW'($signed(box_pos[k*W +: W]));
        assign h_e[k]  = EW'(box_half[k*W +: W]);
        assign mv_e[k] = EW'($signed(box_motion[k*W +: W]));
        assign p_e[k]  = EW'($signed(obj_pos[k*W +: W]));
        assign s_e[k]  = EW'(obj_size[k*W +: W]);
        // The object's vertical extent starts at its y coordinate.
        if (k == 1) begin : g_vert
            assign ov[k] = (b_e[k] + h_e[k] > p_e[k]) &&
                           (b_e[k] - h_e[k] < p_e[k] + s_e[k]);
        end
        else begin : g_horz
            assign ov[k] = (b_e[k] + h_e[k] > p_e[k] - s_e[k]) &&
                           (b_e[k] - h_e[k] < p_e[k] + s_e[k]);
        end
    end

    always_comb
    begin
        case (mode)
            MODE_X:
            begin
                ax        = MODE_X;
                cross_ovl = ov[1] & ov[2];
            end
            MODE_Y:
            begin
                ax        = MODE_Y;
                cross_ovl = ov[0] & ov[2];
            end
            MODE_Z:
            begin
                ax        = MODE_Z;
                cross_ovl = ov[0] & ov[1];
            end
            default:
            begin
                ax        = MODE_X;
                cross_ovl = 1'b0;
            end
        endcase
    end

    assign b    = b_e[ax];
    assign h    = h_e[ax];
    assign mv   = mv_e[ax];
    assign pa   = p_e[ax];
    assign sa   = s_e[ax];
    assign bold = EW'(box_old_axis);
    assign pold = EW'(obj_old_axis);
    assign loff = (mode == MODE_Y) ? '0 : sa;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;

        ctl_next   = ctl_reg;
        bp_next    = bp_reg;
        bpo_next   = bpo_reg;
        ol_next    = ol_reg;
        olo_next   = olo_reg;
        bn_next    = bn_reg;
        bno_next   = bno_reg;
        oho_next   = oho_reg;
        c_old_next = c_old_reg;
        lm_next    = lm_reg;
        sm_next    = sm_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        if (load)
        begin
            ctl_next.no_axis   = (mode == MODE_NONE);
            ctl_next.is_y      = (mode == MODE_Y);
            ctl_next.cross_ovl = cross_ovl;
            ctl_next.pos_hit   = 1'b0;
            ctl_next.mv_neg    = mv[EW-1];
            ctl_next.mv_pos    = !mv[EW-1] && (mv != '0);
            bp_next    = b + h;
            bpo_next   = bold + h;
            ol_next    = pa - loff;
            olo_next   = pold - loff;
            bn_next    = b - h;
            bno_next   = bold - h;
            oho_next   = pold + sa;
            c_old_next = pold + mv;
            lm_next    = loff + mv;
            sm_next    = mv - sa;
            s_next     = sa[W-1:0];
            p_next     = pa[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg   <= ctl_next;
        bp_reg    <= bp_next;
        bpo_reg   <= bpo_next;
        ol_reg    <= ol_next;
        olo_reg   <= olo_next;
        bn_reg    <= bn_next;
        bno_reg   <= bno_next;
        oho_reg   <= oho_next;
        c_old_reg <= c_old_next;
        lm_reg    <= lm_next;
        sm_reg    <= sm_next;
        s_reg     <= s_next;
        p_reg     <= p_next;
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign bp        = bp_reg;
    assign bpo       = bpo_reg;
    assign ol        = ol_reg;
    assign olo       = olo_reg;
    assign bn        = bn_reg;
    assign bno       = bno_reg;
    assign oho       = oho_reg;
    assign c_old     = c_old_reg;
    assign lm        = lm_reg;
    assign sm        = sm_reg;
    assign s         = s_reg;
    assign p         = p_reg;

endmodule

@@ hw/rtl/abcr_pos_face.sv @@
// ----------------------------------------------------------------------------
// abcr_pos_face
// Tests the positive box face and writes the corrected coordinate; also
// saturates the two candidate coordinates of the negative face.
// ----------------------------------------------------------------------------
module abcr_pos_face #(
    parameter int COORD_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  abcr_pkg::abcr_ctl_t             in_ctl,
    input  logic signed [COORD_BITS+2:0]    bp,
    input  logic signed [COORD_BITS+2:0]    bpo,
    input  logic signed [COORD_BITS+2:0]    ol,
    input  logic signed [COORD_BITS+2:0]    olo,
    input  logic signed [COORD_BITS+2:0]    in_bn,
    input  logic signed [COORD_BITS+2:0]    in_bno,
    input  logic signed [COORD_BITS+2:0]    in_oho,
    input  logic signed [COORD_BITS+2:0]    c_old,
    input  logic signed [COORD_BITS+2:0]    lm,
    input  logic signed [COORD_BITS+2:0]    sm,
    input  logic [COORD_BITS-1:0]           in_s,
    input  logic signed [COORD_BITS-1:0]    p,
    output logic                            out_valid,
    input  logic                            out_ready,
    output abcr_pkg::abcr_ctl_t             out_ctl,
    output logic signed [COORD_BITS-1:0]    p1,
    output logic signed [COORD_BITS+2:0]    out_bn,
    output logic signed [COORD_BITS+2:0]    out_bno,
    output logic signed [COORD_BITS+2:0]    out_oho,
    output logic [COORD_BITS-1:0]           out_s,
    output logic signed [COORD_BITS-1:0]    sat_old,
    output logic signed [COORD_BITS-1:0]    sat_neg
);
    import abcr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    // Clamp a wide sum to the signed coordinate range.
    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
        logic signed [W-1:0] r;
        if (v[EW-1:W-1] == {(EW-W+1){v[EW-1]}})
        begin
            r = v[W-1:0];
        end
        else if (v[EW-1])
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    logic                   hit;
    logic signed [EW-1:0]   c_pos;
    logic                   load;

    logic                   valid_reg, valid_next;
    abcr_ctl_t              ctl_reg, ctl_next;
    logic signed [W-1:0]    p1_reg, p1_next;
    logic signed [EW-1:0]   bn_reg, bn_next, bno_reg, bno_next, oho_reg, oho_next;
    logic [W-1:0]           s_reg, s_next;
    logic signed [W-1:0]    sat_old_reg, sat_old_next, sat_neg_reg, sat_neg_next;

    assign hit = in_ctl.cross_ovl && (bp > ol) &&
                 ((bpo <= ol) || (bp <= olo) ||
                  ((bp >= olo) && (bpo <= olo) && (bpo >= ol)));

    assign c_pos = bp + lm;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next   = in_ready ? in_valid : valid_reg;
        ctl_next     = ctl_reg;
        p1_next      = p1_reg;
        bn_next      = bn_reg;
        bno_next     = bno_reg;
        oho_next     = oho_reg;
        s_next       = s_reg;
        sat_old_next = sat_old_reg;
        sat_neg_next = sat_neg_reg;
        if (load)
        begin
            ctl_next         = in_ctl;
            ctl_next.pos_hit = hit;
            // A box moving negative pushes the object out to the face; otherwise the
            // object keeps its own step.
            if (hit)
            begin
                p1_next = in_ctl.mv_neg ? sat_w(c_pos) : sat_w(c_old);
            end
            else
            begin
                p1_next = p;
            end
            bn_next      = in_bn;
            bno_next     = in_bno;
            oho_next     = in_oho;
            s_next       = in_s;
            sat_old_next = sat_w(c_old);
            sat_neg_next = sat_w(in_bn + sm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg     <= ctl_next;
        p1_reg      <= p1_next;
        bn_reg      <= bn_next;
        bno_reg     <= bno_next;
        oho_reg     <= oho_next;
        s_reg       <= s_next;
        sat_old_reg <= sat_old_next;
        sat_neg_reg <= sat_neg_next;
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign p1        = p1_reg;
    assign out_bn    = bn_reg;
    assign out_bno   = bno_reg;
    assign out_oho   = oho_reg;
    assign out_s     = s_reg;
    assign sat_old   = sat_old_reg;
    assign sat_neg   = sat_neg_reg;

endmodule

@@ hw/rtl/abcr_neg_face.sv @@
// ----------------------------------------------------------------------------
// abcr_neg_face
// Tests the negative box face against the coordinate left by the positive
// face and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
module abcr_neg_face #(
    parameter int COORD_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  abcr_pkg::abcr_ctl_t             ctl,
    input  logic signed [COORD_BITS-1:0]    p1,
    input  logic signed [COORD_BITS+2:0]    bn,
    input  logic signed [COORD_BITS+2:0]    bno,
    input  logic signed [COORD_BITS+2:0]    oho,
    input  logic [COORD_BITS-1:0]           s,
    input  logic signed [COORD_BITS-1:0]    sat_old,
    input  logic signed [COORD_BITS-1:0]    sat_neg,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [COORD_BITS-1:0]    obj_axis_out,
    output logic                            pos_written,
    output logic [1:0]                      vel_action,
    output logic                            landed
);
    import abcr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic signed [EW-1:0]   p1_e, s_e, oh;
    logic                   hit;
    logic                   load;

    logic                   valid_reg, valid_next;
    logic signed [W-1:0]    coord_reg, coord_next;
    logic                   written_reg, written_next;
    logic [1:0]             vel_reg, vel_next;
    logic                   landed_reg, landed_next;

    assign p1_e = EW'(p1);
    assign s_e  = EW'(s);
    assign oh   = p1_e + s_e;

    assign hit = ctl.cross_ovl && (bn < oh) &&
                 ((bno >= oh) || (bn >= oho) ||
                  ((bn <= oho) && (bno >= oho) && (bno <= oh)));

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next   = in_ready ? in_valid : valid_reg;
        coord_next   = coord_reg;
        written_next = written_reg;
        vel_next     = vel_reg;
        landed_next  = landed_reg;
        if (load)
        begin
            written_next = ctl.pos_hit || hit;
            landed_next  = ctl.pos_hit && ctl.is_y;
            if (hit)
            begin
                // Hitting the underside always snaps below the box; sideways
                // hits keep the object's own step unless the box closes in.
                if (ctl.is_y || ctl.mv_pos)
                begin
                    coord_next = sat_neg;
                end
                else
                begin
                    coord_next = sat_old;
                end
                vel_next = ctl.is_y ? VEL_BOX_Y : VEL_ZERO;
            end
            else
            begin
                coord_next = p1;
                vel_next   = ctl.pos_hit ? VEL_ZERO : VEL_KEEP;
            end
            if (ctl.no_axis)
            begin
                coord_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg   <= coord_next;
        written_reg <= written_next;
        vel_reg     <= vel_next;
        landed_reg  <= landed_next;
    end

    assign out_valid    = valid_reg;
    assign obj_axis_out = coord_reg;
    assign pos_written  = written_reg;
    assign vel_action   = vel_reg;
    assign landed       = landed_reg;

`ifndef NO_ASSERTIONS
    a_landed_written: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && landed_reg |-> written_reg)
        else $error("landing reported without a position write");

    a_vel_matches_write: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((vel_reg != VEL_KEEP) == written_reg))
        else $error("velocity action disagrees with position write");
`endif

endmodule

@@ hw/rtl/axis_box_collision_resolve_unit.sv @@
// ----------------------------------------------------------------------------
// axis_box_collision_resolve_unit
// Resolves one moving object against one moving box along one axis.
//
// An object and box pair arrives as one transfer on the item channel with the
// axis in mode; the result channel returns the corrected axis coordinate, a
// position write flag, the velocity action and the landing flag. Each item
// gives exactly one result, in order.
// The pipeline has four register stages: input register, face sums, positive
// face, negative face with the result register. A result is offered once its
// item has passed every stage, and one item is taken every cycle while the
// result side keeps up.
// Reset empties every stage; nothing is kept between items.
// When the receiver stalls, each stage holds its item and ready falls back
// stage by stage, so empty stages still fill and up to four items wait.
// Mode 3 selects no axis and returns all fields zero.
// ----------------------------------------------------------------------------
module axis_box_collision_resolve_unit #(
    parameter int COORD_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    abcr_in_if.sink     item,
    abcr_out_if.source  result
);
    import abcr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int PW = 3 * COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic                   in_valid_reg, in_valid_next;
    logic [1:0]             mode_reg, mode_next;
    logic [PW-1:0]          box_pos_reg, box_pos_next;
    logic signed [W-1:0]    box_old_reg, box_old_next;
    logic [PW-1:0]          box_half_reg, box_half_next;
    logic [PW-1:0]          box_motion_reg, box_motion_next;
    logic [PW-1:0]          obj_pos_reg, obj_pos_next;
    logic signed [W-1:0]    obj_old_reg, obj_old_next;
    logic [PW-1:0]          obj_size_reg, obj_size_next;
    logic                   load;

    logic                   prep_ready, prep_valid;
    abcr_ctl_t              prep_ctl;
    logic signed [EW-1:0]   prep_bp, prep_bpo, prep_ol, prep_olo;
    logic signed [EW-1:0]   prep_bn, prep_bno, prep_oho, prep_c_old, prep_lm, prep_sm;
    logic [W-1:0]           prep_s;
    logic signed [W-1:0]    prep_p;

    logic                   pos_ready, pos_valid;
    abcr_ctl_t              pos_ctl;
    logic signed [W-1:0]    pos_p1, pos_sat_old, pos_sat_neg;
    logic signed [EW-1:0]   pos_bn, pos_bno, pos_oho;
    logic [W-1:0]           pos_s;

    logic                   neg_ready;

    assign item.ready = !in_valid_reg || prep_ready;
    assign load       = item.valid && item.ready;

    always_comb
    begin
        in_valid_next   = item.ready ? item.valid : in_valid_reg;
        mode_next       = mode_reg;
        box_pos_next    = box_pos_reg;
        box_old_next    = box_old_reg;
        box_half_next   = box_half_reg;
        box_motion_next = box_motion_reg;
        obj_pos_next    = obj_pos_reg;
        obj_old_next    = obj_old_reg;
        obj_size_next   = obj_size_reg;
        if (load)
        begin
            mode_next       = item.mode;
            box_pos_next    = item.box_pos;
            box_old_next    = item.box_old_axis;
            box_half_next   = item.box_half;
            box_motion_next = item.box_motion;
            obj_pos_next    = item.obj_pos;
            obj_old_next    = item.obj_old_axis;
            obj_size_next   = item.obj_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        box_pos_reg    <= box_pos_next;
        box_old_reg    <= box_old_next;
        box_half_reg   <= box_half_next;
        box_motion_reg <= box_motion_next;
        obj_pos_reg    <= obj_pos_next;
        obj_old_reg    <= obj_old_next;
        obj_size_reg   <= obj_size_next;
    end

    abcr_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid_reg),
        .in_ready     (prep_ready),
        .mode         (mode_reg),
        .box_pos      (box_pos_reg),
        .box_old_axis (box_old_reg),
        .box_half     (box_half_reg),
        .box_motion   (box_motion_reg),
        .obj_pos      (obj_pos_reg),
        .obj_old_axis (obj_old_reg),
        .obj_size     (obj_size_reg),
        .out_valid    (prep_valid),
        .out_ready    (pos_ready),
        .ctl          (prep_ctl),
        .bp           (prep_bp),
        .bpo          (prep_bpo),
        .ol           (prep_ol),
        .olo          (prep_olo),
        .bn           (prep_bn),
        .bno          (prep_bno),
        .oho          (prep_oho),
        .c_old        (prep_c_old),
        .lm           (prep_lm),
        .sm           (prep_sm),
        .s            (prep_s),
        .p            (prep_p)
    );

    abcr_pos_face #(
        .COORD_BITS (COORD_BITS)
    ) u_pos_face (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (pos_ready),
        .in_ctl    (prep_ctl),
        .bp        (prep_bp),
        .bpo       (prep_bpo),
        .ol        (prep_ol),
        .olo       (prep_olo),
        .in_bn     (prep_bn),
        .in_bno    (prep_bno),
        .in_oho    (prep_oho),
        .c_old     (prep_c_old),
        .lm        (prep_lm),
        .sm        (prep_sm),
        .in_s      (prep_s),
        .p         (prep_p),
        .out_valid (pos_valid),
        .out_ready (neg_ready),
        .out_ctl   (pos_ctl),
        .p1        (pos_p1),
        .out_bn    (pos_bn),
        .out_bno   (pos_bno),
        .out_oho   (pos_oho),
        .out_s     (pos_s),
        .sat_old   (pos_sat_old),
        .sat_neg   (pos_sat_neg)
    );

    abcr_neg_face #(
        .COORD_BITS (COORD_BITS)
    ) u_neg_face (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pos_valid),
        .in_ready     (neg_ready),
        .ctl          (pos_ctl),
        .p1           (pos_p1),
        .bn           (pos_bn),
        .bno          (pos_bno),
        .oho          (pos_oho),
        .s            (pos_s),
        .sat_old      (pos_sat_old),
        .sat_neg      (pos_sat_neg),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .obj_axis_out (result.obj_axis_out),
        .pos_written  (result.pos_written),
        .vel_action   (result.vel_action),
        .landed       (result.landed)
    );

`ifndef NO_ASSERTIONS
    a_empty_out_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> item.ready)
        else $error("item channel stalled while the result register is empty");
`endif

endmodule
